>>> rtl/core/salru_pkg.sv
// Package with the payload types, register indexes and fixed widths of the LRU cache block.
package salru_pkg;

    // Fixed field widths.
    localparam int unsigned ADDR_FIELD_W = 16;
    localparam int unsigned WAY_FIELD_W  = 3;
    localparam int unsigned COUNT_W      = 32;
    localparam int unsigned RAW_SET_W    = 7;
    localparam int unsigned MIN_OFFSET   = 2;

    // Configuration port shape.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_SET_BITS    = 2'd1,
        CFG_WAYS_IN_USE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_FIELD_W-1:0] address;
        logic                    new_batch;
    } t_in_item;

    typedef struct packed {
        logic                   hit;
        logic [WAY_FIELD_W-1:0] way;
        logic [COUNT_W-1:0]     hit_count;
        logic [COUNT_W-1:0]     miss_count;
    } t_out_item;

endpackage

>>> rtl/core/set_assoc_cache_true_lru.sv
// Top level of the tag-only set-associative cache with matrix true LRU replacement.
//
//  channel   direction  handshake                   payload
//  request   in         i_in_valid / o_in_stall     i_in  (address, new_batch)
//  result    out        o_out_valid / i_out_stall   o_out (hit, way, hit_count, miss_count)
//  config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One request per cycle is sustained while results are not stalled. A request is registered
// into the lookup stage, and its result is registered from there into the result register.
// The lookup stage does the read-modify-write of one set's state (tags, valid bits, LRU
// matrix), with a bypass when back-to-back requests hit the same set.
// Reset is synchronous and active low; it clears control state and one flag per set, so
// no clearing pass is run and a set never touched reads as empty at once.
// A stalled result holds the lookup stage, and the request side stalls only then.
module set_assoc_cache_true_lru #(
    parameter int unsigned MAX_SETS  = 128,
    parameter int unsigned MAX_WAYS  = 8,
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  salru_pkg::t_in_item           i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output salru_pkg::t_out_item          o_out,
    input  logic                          i_cfg_we,
    input  logic [salru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [salru_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import salru_pkg::*;

    // The smallest offset and an empty set index leave this many tag bits.
    localparam int unsigned TAG_W = ADDR_BITS - MIN_OFFSET;
    localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int unsigned RAW_SETS = 1 << RAW_SET_W;

    // Configuration registers.
    logic [2:0] r_offset_bits;
    logic [2:0] r_set_bits;
    logic [3:0] r_ways_in_use;

    // Set state memories; a set whose flag is clear reads with all valid bits and LRU bits zero.
    logic [MAX_WAYS-1:0]               m_vld [MAX_SETS];
    logic [MAX_WAYS-1:0][MAX_WAYS-1:0] m_lru [MAX_SETS];
    logic [MAX_SETS-1:0]               r_row_vld;

    // Lookup stage.
    logic                              r_s1_valid;
    logic [SET_W-1:0]                  r_s1_set;
    logic [TAG_W-1:0]                  r_s1_tag;
    logic                              r_s1_new_batch;
    logic                              r_rd_rowv;
    logic [MAX_WAYS-1:0]               r_rd_vld;
    logic [MAX_WAYS-1:0][MAX_WAYS-1:0] r_rd_lru;
    logic [MAX_WAYS-1:0][TAG_W-1:0]    r_rd_tag;
    logic                              r_fwd;
    logic [MAX_WAYS-1:0]               r_fwd_vld;
    logic [MAX_WAYS-1:0][MAX_WAYS-1:0] r_fwd_lru;
    logic [MAX_WAYS-1:0][TAG_W-1:0]    r_fwd_tag;

    // Counters and result register.
    logic [COUNT_W-1:0] r_hits;
    logic [COUNT_W-1:0] r_misses;
    logic [COUNT_W-1:0] n_hits;
    logic [COUNT_W-1:0] n_misses;
    logic               r_out_valid;
    t_out_item          r_out;

    logic                 in_fire;
    logic                 out_free;
    logic                 s1_adv;
    logic [2:0]           eff_offset;
    logic [ADDR_BITS-1:0] in_addr;
    logic [RAW_SET_W-1:0] in_raw_set;
    logic [SET_W-1:0]     in_set;
    logic [TAG_W-1:0]     in_tag;
    logic [SET_W-1:0]     set_map [RAW_SETS];
    logic [4:0]           ways_clamped;
    logic [MAX_WAYS-1:0]  ways_mask;

    logic [MAX_WAYS-1:0]               eff_vld;
    logic [MAX_WAYS-1:0][MAX_WAYS-1:0] eff_lru;
    logic [MAX_WAYS-1:0][TAG_W-1:0]    eff_tag;
    logic [MAX_WAYS-1:0][TAG_W-1:0]    upd_tag;
    logic                              lk_hit;
    logic [WAY_W-1:0]                  lk_way;
    logic [MAX_WAYS-1:0]               lk_vld;
    logic [MAX_WAYS-1:0][MAX_WAYS-1:0] lk_lru;

    // Handshakes: the lookup stage moves when the result register is free or drains.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign s1_adv      = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Set indexes past the storage wrap around it; the map is built at elaboration.
    for (genvar g = 0; g < RAW_SETS; g++) begin : g_set_map
        assign set_map[g] = SET_W'(g % MAX_SETS);
    end

    // Address split. Users hold configuration stable while requests are in flight; not checked.
    always_comb begin
        eff_offset = (r_offset_bits < 3'(MIN_OFFSET)) ? 3'(MIN_OFFSET) : r_offset_bits;
        in_addr    = ADDR_BITS'(i_in.address);
        in_raw_set = RAW_SET_W'(in_addr >> eff_offset)
                   & RAW_SET_W'((8'd1 << r_set_bits) - 8'd1);
        in_set     = set_map[in_raw_set];
        in_tag     = TAG_W'(in_addr >> ({1'b0, eff_offset} + {1'b0, r_set_bits}));
    end

    // Ways in use, with zero taken as one and values above the storage cut to it.
    always_comb begin
        if (r_ways_in_use == '0) begin
            ways_clamped = 5'd1;
        end else if (r_ways_in_use > MAX_WAYS) begin
            ways_clamped = 5'(MAX_WAYS);
        end else begin
            ways_clamped = {1'b0, r_ways_in_use};
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            ways_mask[i] = (5'(i) < ways_clamped);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 3'd4;
            r_set_bits    <= 3'd3;
            r_ways_in_use <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[2:0];
                CFG_SET_BITS:    r_set_bits    <= i_cfg_data[2:0];
                CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid-bit and LRU memories: read on request transfer, written when the lookup moves on.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd_vld <= m_vld[in_set];
            r_rd_lru <= m_lru[in_set];
        end
        if (s1_adv) begin
            m_vld[r_s1_set] <= lk_vld;
            m_lru[r_s1_set] <= lk_lru;
        end
    end

    // One tag memory per way; only the refilled way is written, and only on a miss.
    for (genvar g = 0; g < MAX_WAYS; g++) begin : g_tag_mem
        logic [TAG_W-1:0] m_tag [MAX_SETS];
        always_ff @(posedge i_clk) begin
            if (in_fire) begin
                r_rd_tag[g] <= m_tag[in_set];
            end
            if (s1_adv && !lk_hit && (lk_way == WAY_W'(g))) begin
                m_tag[r_s1_set] <= r_s1_tag;
            end
        end
    end

    // Tag row as the lookup leaves it, used for the bypass.
    always_comb begin
        upd_tag = eff_tag;
        upd_tag[lk_way] = r_s1_tag;
    end

    // Lookup stage registers. When the request just taken reads the set that the
    // leaving request writes in the same cycle, the written row is caught here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_row_vld  <= '0;
            r_fwd      <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_row_vld[r_s1_set] <= 1'b1;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_adv && (r_s1_set == in_set);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_set       <= in_set;
            r_s1_tag       <= in_tag;
            r_s1_new_batch <= i_in.new_batch;
            r_rd_rowv      <= r_row_vld[in_set];
            r_fwd_vld      <= lk_vld;
            r_fwd_lru      <= lk_lru;
            r_fwd_tag      <= upd_tag;
        end
    end

    always_comb begin
        if (r_fwd) begin
            eff_vld = r_fwd_vld;
            eff_lru = r_fwd_lru;
            eff_tag = r_fwd_tag;
        end else begin
            eff_vld = r_rd_rowv ? r_rd_vld : '0;
            eff_lru = r_rd_rowv ? r_rd_lru : '0;
            eff_tag = r_rd_tag;
        end
    end

    salru_lookup #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W),
        .WAY_W    (WAY_W)
    ) u_lookup (
        .i_tag       (r_s1_tag),
        .i_ways_mask (ways_mask),
        .i_vld       (eff_vld),
        .i_lru       (eff_lru),
        .i_tags      (eff_tag),
        .o_hit       (lk_hit),
        .o_way       (lk_way),
        .o_vld       (lk_vld),
        .o_lru       (lk_lru)
    );

    // Batch counts restart before the request that carries new_batch.
    always_comb begin
        n_hits   = r_s1_new_batch ? '0 : r_hits;
        n_misses = r_s1_new_batch ? '0 : r_misses;
        if (lk_hit) begin
            n_hits = n_hits + COUNT_W'(1);
        end else begin
            n_misses = n_misses + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.hit        <= lk_hit;
            r_out.way        <= WAY_FIELD_W'(lk_way);
            r_out.hit_count  <= n_hits;
            r_out.miss_count <= n_misses;
        end
    end

endmodule

>>> rtl/core/salru_lookup.sv
// Tag compare, matrix LRU victim pick and set state update for one request.
module salru_lookup #(
    parameter int unsigned MAX_WAYS = 8,
    parameter int unsigned TAG_W    = 14,
    parameter int unsigned WAY_W    = 3
) (
    input  logic [TAG_W-1:0]                   i_tag,
    input  logic [MAX_WAYS-1:0]                i_ways_mask,
    input  logic [MAX_WAYS-1:0]                i_vld,
    input  logic [MAX_WAYS-1:0][MAX_WAYS-1:0]  i_lru,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]     i_tags,
    output logic                               o_hit,
    output logic [WAY_W-1:0]                   o_way,
    output logic [MAX_WAYS-1:0]                o_vld,
    output logic [MAX_WAYS-1:0][MAX_WAYS-1:0]  o_lru
);

    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] victim_way;

    always_comb begin
        o_hit      = 1'b0;
        hit_way    = '0;
        victim_way = '0;
        // Walk downward so the lowest matching way wins.
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (i_ways_mask[i] && i_vld[i] && (i_tags[i] == i_tag)) begin
                o_hit   = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (i_ways_mask[i] && ((i_lru[i] & i_ways_mask) == '0)) begin
                victim_way = WAY_W'(i);
            end
        end
        o_way = o_hit ? hit_way : victim_way;

        // The used way becomes most recent: its row goes to ones, then its column clears.
        o_lru        = i_lru;
        o_lru[o_way] = i_lru[o_way] | i_ways_mask;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i_ways_mask[i]) begin
                o_lru[i][o_way] = 1'b0;
            end
        end

        o_vld        = i_vld;
        o_vld[o_way] = 1'b1;
    end

endmodule

>>> test/tb.sv
// Self-checking testbench for the tag-only set-associative cache with matrix true LRU.
`timescale 1ns / 1ps

module tb;

    import salru_pkg::*;

    // A correct run needs far fewer cycles than this. The limit only catches a hung block.
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETS_HELD   = 128;
    localparam int unsigned WAYS_HELD   = 8;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_ITEMS = 80;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;

    // Request side, driven by this bench.
    logic       in_valid = 1'b0;
    t_in_item   in_item  = '0;
    logic       o_in_stall;

    // Result side, stalled by this bench.
    logic       o_out_valid;
    logic       out_stall = 1'b0;
    t_out_item  o_out;

    // Register write port.
    logic       cfg_we   = 1'b0;
    t_cfg_idx   cfg_idx  = CFG_OFFSET_BITS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Requests waiting to be offered, and lookup results that the block still owes.
    t_in_item   requests_to_send [$];
    t_out_item  lookup_results_due [$];

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // Pacing of both sides: a wait count before the next transfer and a run of zero waits.
    int send_wait   = 0;
    int send_streak = 0;
    int recv_wait   = 0;
    int recv_streak = 0;

    // Shadow copy of the cache: register values, tags, valid bits, LRU matrices and counts.
    // Row r of a set's matrix has bit c set when way r was used more recently than way c.
    bit [2:0]  line_shift = 3'd4;
    bit [2:0]  set_shift  = 3'd3;
    bit [3:0]  way_count  = 4'd1;
    bit [15:0] tag_mem    [SETS_HELD][WAYS_HELD];
    bit        line_valid [SETS_HELD][WAYS_HELD];
    bit [7:0]  recency    [SETS_HELD][WAYS_HELD];
    bit [31:0] hit_total  = '0;
    bit [31:0] miss_total = '0;

    // Random configurations for the random part. The first three shrink and then widen the
    // associativity on one set, so stale LRU rows can leave no all-zero row over the ways
    // in use. Offsets below two, zero ways and ways above the maximum are also covered.
    bit [2:0] phase_ob   [PHASES] = '{3'd2, 3'd2, 3'd2, 3'd0, 3'd1, 3'd7,
                                      3'd4, 3'd3, 3'd5, 3'd6, 3'd7, 3'd2};
    bit [2:0] phase_sb   [PHASES] = '{3'd0, 3'd0, 3'd0, 3'd1, 3'd7, 3'd7,
                                      3'd3, 3'd5, 3'd2, 3'd1, 3'd0, 3'd6};
    bit [3:0] phase_ways [PHASES] = '{4'd8, 4'd3, 4'd8, 4'd0, 4'd15, 4'd8,
                                      4'd2, 4'd9, 4'd4, 4'd5, 4'd1, 4'd7};

    set_assoc_cache_true_lru DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Works out the result of one lookup and updates the shadow cache, exactly as the
    // block is meant to when it takes this request.
    function automatic t_out_item predict_lookup(t_in_item req);
        t_out_item res;
        int        ob;
        int        k;
        int        set_no;
        int        way_no;
        int        i;
        bit [15:0] tag_val;
        bit [7:0]  in_use;
        bit        found;
        bit        picked;
        // Offsets narrower than two bits are widened, and the way count is clamped to 1..8.
        ob = (line_shift < 2) ? 2 : line_shift;
        k  = (way_count == 0) ? 1 : ((way_count > WAYS_HELD) ? WAYS_HELD : way_count);
        in_use  = 8'((1 << k) - 1);
        set_no  = (req.address >> ob) & ((1 << set_shift) - 1);
        tag_val = req.address >> (ob + set_shift);
        found   = 1'b0;
        picked  = 1'b0;
        way_no  = 0;
        if (req.new_batch) begin
            hit_total  = '0;
            miss_total = '0;
        end
        for (i = 0; i < k; i++) begin
            if (!found && line_valid[set_no][i] && tag_mem[set_no][i] == tag_val) begin
                found  = 1'b1;
                way_no = i;
            end
        end
        if (found) begin
            hit_total++;
        end else begin
            miss_total++;
            // The victim is the first way whose row is empty over the ways in use. When
            // none is empty, which only a change of the way count can cause, way 0 goes.
            for (i = 0; i < k; i++) begin
                if (!picked && (recency[set_no][i] & in_use) == 8'd0) begin
                    picked = 1'b1;
                    way_no = i;
                end
            end
            tag_mem[set_no][way_no]    = tag_val;
            line_valid[set_no][way_no] = 1'b1;
        end
        // The used way becomes most recent: its row fills, then its column clears.
        recency[set_no][way_no] |= in_use;
        for (i = 0; i < k; i++) begin
            recency[set_no][i][way_no] = 1'b0;
        end
        res.hit        = found;
        res.way        = way_no[WAY_FIELD_W-1:0];
        res.hit_count  = hit_total;
        res.miss_count = miss_total;
        return res;
    endfunction

    // Picks how many cycles a side holds off before its next transfer. Now and then a run
    // of back-to-back transfers starts, so that full rate is exercised as well.
    function automatic int draw_pause(inout int streak);
        if (streak > 0) begin
            streak--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            streak = $urandom_range(6, 30);
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_request(bit [15:0] addr, bit batch_start);
        t_in_item req;
        req.address   = addr;
        req.new_batch = batch_start;
        requests_to_send.push_back(req);
    endtask

    // Register writes happen only while the block is idle. All three registers are written
    // on consecutive edges, and the shadow copy follows once the last write has landed.
    task automatic apply_shape(bit [2:0] ob, bit [2:0] sb, bit [3:0] ways);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_OFFSET_BITS;
        cfg_data <= {1'b0, ob};
        @(posedge i_clk);
        cfg_idx  <= CFG_SET_BITS;
        cfg_data <= {1'b0, sb};
        @(posedge i_clk);
        cfg_idx  <= CFG_WAYS_IN_USE;
        cfg_data <= ways;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        line_shift = ob;
        set_shift  = sb;
        way_count  = ways;
        @(negedge i_clk);
    endtask

    // Waits until every request has been taken and every result has come back, then waits on
    // beyond that so that a stray extra result would still be seen.
    task automatic wait_until_idle();
        while (requests_to_send.size() != 0 || in_valid || lookup_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Request driver. A request is taken at an edge where valid is high and stall is low;
    // at that edge its result is predicted. A stalled request stays on the port unchanged.
    always @(posedge i_clk) begin : drive_requests
        bit port_free;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            port_free = !in_valid;
            if (in_valid && !o_in_stall) begin
                lookup_results_due.push_back(predict_lookup(in_item));
                port_free = 1'b1;
            end
            if (port_free) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (requests_to_send.size() != 0) begin
                    in_item   <= requests_to_send.pop_front();
                    in_valid  <= 1'b1;
                    send_wait = draw_pause(send_streak);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Each result transfer is checked against the oldest prediction, and
    // after it the stall line is held high for a freshly drawn number of cycles.
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (lookup_results_due.size() == 0) begin
                    $display("%0t: expected no result, got hit %0d way %0d",
                             $time, o_out.hit, o_out.way);
                    mismatches++;
                end else begin
                    want = lookup_results_due.pop_front();
                    check_field("hit", want.hit, o_out.hit);
                    check_field("way", want.way, o_out.way);
                    check_field("hit_count", want.hit_count, o_out.hit_count);
                    check_field("miss_count", want.miss_count, o_out.miss_count);
                end
                recv_wait = draw_pause(recv_streak);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog against a block that stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("set_assoc_cache_true_lru: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int ph;
        int n;
        int ob_e;
        int k_e;
        int set_span;
        int tag_pick;
        int set_pick;
        int addr;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset shape: 16-byte lines, eight sets, one way. A second access to the same line
        // hits, and another tag in the same set must replace the only way.
        queue_request(16'h0000, 1'b0);
        queue_request(16'h000F, 1'b0);
        queue_request(16'h0080, 1'b0);
        queue_request(16'h0005, 1'b0);
        wait_until_idle();

        // One set with four ways: fill every way, hit on both tag extremes, then force
        // LRU evictions and restart the counts on a hit and on a miss.
        apply_shape(3'd2, 3'd0, 4'd4);
        queue_request(16'h0000, 1'b1);
        queue_request(16'hFFFF, 1'b0);
        queue_request(16'h0003, 1'b0);
        queue_request(16'h0010, 1'b0);
        queue_request(16'h0020, 1'b0);
        queue_request(16'hFFFC, 1'b0);
        queue_request(16'h0030, 1'b0);
        queue_request(16'h0001, 1'b0);
        queue_request(16'hFFFE, 1'b1);
        queue_request(16'h5555, 1'b0);
        queue_request(16'hAAAA, 1'b1);
        queue_request(16'h0020, 1'b0);
        wait_until_idle();

        // Widest offset and set index with all eight ways: only two tag bits remain.
        apply_shape(3'd7, 3'd7, 4'd8);
        queue_request(16'hFFFF, 1'b0);
        queue_request(16'h0000, 1'b0);
        queue_request(16'h3FFF, 1'b0);
        queue_request(16'hC000, 1'b0);
        queue_request(16'hFFFF, 1'b0);
        queue_request(16'h4000, 1'b0);
        wait_until_idle();

        // Random part. Most requests draw from a few sets and from slightly more tags than
        // there are ways, so hits, refills and LRU evictions all happen often. The rest are
        // fully random addresses. Cache contents carry over from one phase to the next.
        for (ph = 0; ph < PHASES; ph++) begin
            apply_shape(phase_ob[ph], phase_sb[ph], phase_ways[ph]);
            ob_e = (phase_ob[ph] < 2) ? 2 : phase_ob[ph];
            k_e  = (phase_ways[ph] == 0) ? 1 :
                   ((phase_ways[ph] > WAYS_HELD) ? WAYS_HELD : phase_ways[ph]);
            set_span = (phase_sb[ph] >= 2) ? 4 : (1 << phase_sb[ph]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 20) begin
                    addr = $urandom_range(0, 16'hFFFF);
                end else begin
                    tag_pick = $urandom_range(0, k_e + 1);
                    set_pick = $urandom_range(0, set_span - 1);
                    addr = (tag_pick << (ob_e + phase_sb[ph])) | (set_pick << ob_e)
                         | $urandom_range(0, (1 << ob_e) - 1);
                end
                queue_request(addr[15:0], $urandom_range(0, 15) == 0);
            end
            wait_until_idle();
        end

        if (mismatches == 0) begin
            $display("set_assoc_cache_true_lru: match");
        end else begin
            $display("set_assoc_cache_true_lru: mismatch");
        end
        $finish;
    end

endmodule
